@@ rtl/wifi_two_phase_frame_filter_top_macros.svh @@
// Assertion macros for the frame filter.
`ifndef WIFI_TWO_PHASE_FRAME_FILTER_TOP_MACROS_SVH
`define WIFI_TWO_PHASE_FRAME_FILTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies a consequence in the same cycle.
`define WTF_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define WTF_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define WTF_ASSERT_IMPL(label, clk, rst, cond, prop)
`define WTF_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

@@ rtl/wtf_pkg.sv @@
`timescale 1ns / 1ps
package wtf_pkg;
  localparam int EAPOL_LIMIT_DEF       = 4;
  localparam int CAPTURE_SLOTS_DEF     = 8;
  localparam int FRAME_STORE_BYTES_DEF = 2048;
  localparam int SSID_MAX              = 32;

  localparam logic [11:0] IE_START   = 12'd36;
  localparam logic [15:0] EAPOL_TYPE = 16'h888E;
  localparam logic [11:0] MIN_CLEAN  = 12'd24;
  localparam logic [3:0]  SUB_BEACON = 4'h8;

  localparam logic [2:0] REG_SSID0   = 3'd0;
  localparam logic [2:0] REG_SSID1   = 3'd1;
  localparam logic [2:0] REG_SSID2   = 3'd2;
  localparam logic [2:0] REG_SSID3   = 3'd3;
  localparam logic [2:0] REG_SSIDLEN = 3'd4;
  localparam logic [2:0] REG_BFILT   = 3'd5;
  localparam logic [2:0] REG_BFON    = 3'd6;

  localparam logic [1:0] CLS_MGMT = 2'd0;
  localparam logic [1:0] CLS_DATA = 2'd2;

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_EAPOL = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [1:0] V_IGNORE = 2'd0;
  localparam logic [1:0] V_BEACON = 2'd1;
  localparam logic [1:0] V_EAPOL  = 2'd2;

  // Frame summary handed from the parser to the decision stage.
  typedef struct packed {
    logic        err;
    logic [11:0] eff;
    logic [11:0] clean;
    logic [1:0]  cls;
    logic [15:0] fc;
    logic [47:0] addr3;
    logic [47:0] bssid_at;
    logic [11:0] elem_start;
    logic [7:0]  elem_len;
    logic        ssid_found;
    logic [15:0] ether_type;
  } frame_sum_t;

  // Target SSID settings used by the decision stage.
  typedef struct packed {
    logic [255:0] text;
    logic [5:0]   len;
  } ssid_cfg_t;
endpackage

@@ rtl/wtf_parser.sv @@
`timescale 1ns / 1ps
module wtf_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [11:0]         frame_length,
  input  logic [1:0]          packet_class,
  input  logic                rx_error,
  output logic                sum_valid,
  output wtf_pkg::frame_sum_t sum,
  output logic [255:0]        ssid_text
);
  import wtf_pkg::*;

  logic [11:0]  byte_position;
  logic [11:0]  clean_count;
  logic [15:0]  frame_control;
  logic [47:0]  address_three;
  logic [47:0]  bssid_at;
  logic [11:0]  element_start;
  logic [7:0]   elem_tag;
  logic [7:0]   elem_len;
  logic         ssid_found;
  logic [255:0] ssid_capture;
  logic [15:0]  ether_type;
  logic         err_seen;

  logic [11:0] clean;
  logic [11:0] p;
  logic [15:0] fc_cur;
  logic [1:0]  ds;
  logic [11:0] bstart;
  logic [11:0] hdr;
  logic [12:0] tstart;
  logic [12:0] nlen;
  logic [12:0] poff;

  assign clean  = (frame_length > 12'd4) ? frame_length - 12'd4 : frame_length;
  assign p      = byte_position;
  assign fc_cur = (p == 12'd1) ? {data_byte, frame_control[7:0]} : frame_control;
  assign ds     = frame_control[9:8];
  assign bstart = (ds == 2'd1) ? 12'd4 : ((ds == 2'd2) ? 12'd10 : 12'd16);
  assign hdr    = 12'd24 + (frame_control[7] ? 12'd2 : 12'd0) + ((ds == 2'd3) ? 12'd6 : 12'd0);
  assign tstart = {1'b0, element_start} + 13'd2;
  assign nlen   = (elem_len > 8'd32) ? 13'd32 : {5'd0, elem_len};
  assign poff   = {1'b0, p} - tstart;

  // Parse clean bytes, close the frame on the last byte
  always_ff @(posedge clk) begin
    sum_valid <= 1'b0;
    if (rst) begin
      byte_position <= '0;
      clean_count   <= '0;
      frame_control <= '0;
      address_three <= '0;
      bssid_at      <= '0;
      element_start <= IE_START;
      elem_tag      <= '0;
      elem_len      <= '0;
      ssid_found    <= 1'b0;
      ssid_capture  <= '0;
      ether_type    <= '0;
      err_seen      <= 1'b0;
    end else if (in_valid) begin
      if (last_byte) begin
        sum_valid      <= 1'b1;
        sum.err        <= err_seen | rx_error;
        sum.eff        <= (p < clean) ? clean_count + 12'd1 : clean_count;
        sum.clean      <= clean;
        sum.cls        <= packet_class;
        sum.fc         <= (p >= clean) ? frame_control :
                          ((p == 12'd0) ? {frame_control[15:8], data_byte} : fc_cur);
        sum.addr3      <= address_three;
        sum.bssid_at   <= bssid_at;
        sum.elem_start <= element_start;
        sum.elem_len   <= elem_len;
        sum.ssid_found <= ssid_found;
        sum.ether_type <= ether_type;
        ssid_text      <= ssid_capture;
        if (p < clean) begin
          // Final byte may still land in a header or element field
          if (p >= 12'd16 && p < 12'd22)
            sum.addr3[8*(p-12'd16) +: 8] <= data_byte;
          if (p >= 12'd2 && p >= bstart && p < bstart + 12'd6)
            sum.bssid_at[8*(p-bstart) +: 8] <= data_byte;
          if (p >= 12'd2 && p == hdr + 12'd6) sum.ether_type[15:8] <= data_byte;
          if (p >= 12'd2 && p == hdr + 12'd7) sum.ether_type[7:0] <= data_byte;
          if (!ssid_found && p == element_start + 12'd1 && elem_tag == 8'd0) begin
            sum.ssid_found <= 1'b1;
            sum.elem_len   <= data_byte;
          end
          if (ssid_found && {1'b0, p} >= tstart && {1'b0, p} < tstart + nlen)
            ssid_text[8*poff[4:0] +: 8] <= data_byte;
        end
        byte_position <= '0;
        clean_count   <= '0;
        frame_control <= '0;
        address_three <= '0;
        bssid_at      <= '0;
        element_start <= IE_START;
        elem_tag      <= '0;
        elem_len      <= '0;
        ssid_found    <= 1'b0;
        ssid_capture  <= '0;
        ether_type    <= '0;
        err_seen      <= 1'b0;
      end else begin
        if (rx_error) err_seen <= 1'b1;
        if (byte_position != 12'hFFF) byte_position <= byte_position + 12'd1;
        if (p < clean) begin
          clean_count <= clean_count + 12'd1;
          if (p == 12'd0) frame_control[7:0] <= data_byte;
          if (p == 12'd1) frame_control[15:8] <= data_byte;
          if (p >= 12'd16 && p < 12'd22)
            address_three[8*(p-12'd16) +: 8] <= data_byte;
          if (p >= 12'd2 && p >= bstart && p < bstart + 12'd6)
            bssid_at[8*(p-bstart) +: 8] <= data_byte;
          if (p >= 12'd2 && p == hdr + 12'd6) ether_type[15:8] <= data_byte;
          if (p >= 12'd2 && p == hdr + 12'd7) ether_type[7:0] <= data_byte;
          if (!ssid_found) begin
            if (p == element_start) elem_tag <= data_byte;
            else if (p == element_start + 12'd1) begin
              elem_len <= data_byte;
              if (elem_tag == 8'd0) ssid_found <= 1'b1;
              else element_start <= element_start + 12'd2 + {4'd0, data_byte};
            end
          end else if ({1'b0, p} >= tstart && {1'b0, p} < tstart + nlen) begin
            ssid_capture[8*poff[4:0] +: 8] <= data_byte;
          end
        end
      end
    end
  end
endmodule

@@ rtl/wtf_fifo.sv @@
`timescale 1ns / 1ps
module wtf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             is_empty,
  output logic             is_full
);
  localparam int AW = $clog2(DEPTH);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign rdata    = mem[rp];
  assign is_empty = (cnt == '0);
  assign is_full  = (cnt == (AW+1)'(DEPTH));

  // Advance pointers on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) begin
        mem[wp] <= wdata;
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

@@ rtl/wtf_decide.sv @@
`timescale 1ns / 1ps
module wtf_decide #(
  parameter int EAPOL_LIMIT       = wtf_pkg::EAPOL_LIMIT_DEF,
  parameter int CAPTURE_SLOTS     = wtf_pkg::CAPTURE_SLOTS_DEF,
  parameter int FRAME_STORE_BYTES = wtf_pkg::FRAME_STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  wtf_pkg::frame_sum_t sum,
  input  logic [255:0]        ssid_text,
  input  wtf_pkg::ssid_cfg_t  scfg,
  input  logic [47:0]         bssid_filter,
  input  logic                bssid_filter_on,
  output logic [1:0]          verdict,
  output logic                stored,
  output logic [2:0]          slot_index,
  output logic [11:0]         stored_length,
  output logic [1:0]          phase,
  output logic [2:0]          eapol_count,
  output logic [47:0]         learned_bssid
);
  import wtf_pkg::*;

  logic [1:0]  phase_reg;
  logic [2:0]  accepted_eapol;
  logic [3:0]  slots_used;
  logic [47:0] bssid_learned_reg;

  logic [5:0]  tlen, elen;
  logic [5:0]  lim, n;
  logic        text_eq, ssid_ok, beacon_ok, eapol_ok, slot_free;
  logic [12:0] elem_end;
  logic [11:0] hdr, slen;
  logic [1:0]  ds;

  // Effective target and element lengths: saturate, stop at first zero byte; compare text
  always_comb begin
    lim  = (scfg.len > 6'd32) ? 6'd32 : scfg.len;
    tlen = lim;
    for (int k = SSID_MAX - 1; k >= 0; k--)
      if (6'(k) < lim && scfg.text[8*k +: 8] == 8'd0) tlen = 6'(k);
    n    = (sum.elem_len > 8'd32) ? 6'd32 : sum.elem_len[5:0];
    elen = n;
    for (int k = SSID_MAX - 1; k >= 0; k--)
      if (6'(k) < n && ssid_text[8*k +: 8] == 8'd0) elen = 6'(k);
    text_eq = 1'b1;
    for (int k = 0; k < SSID_MAX; k++)
      if (6'(k) < tlen && ssid_text[8*k +: 8] != scfg.text[8*k +: 8]) text_eq = 1'b0;
  end

  assign elem_end  = {1'b0, sum.elem_start} + 13'd2 + {5'd0, sum.elem_len};
  assign ssid_ok   = (tlen == 6'd0) ||
                     (sum.ssid_found && elem_end <= {1'b0, sum.eff} && elen == tlen && text_eq);
  assign ds        = sum.fc[9:8];
  assign hdr       = 12'd24 + (sum.fc[7] ? 12'd2 : 12'd0) + ((ds == 2'd3) ? 12'd6 : 12'd0);
  assign slot_free = (slots_used < 4'(CAPTURE_SLOTS));
  assign beacon_ok = !sum.err && sum.eff >= MIN_CLEAN && phase_reg == PH_HUNT &&
                     sum.cls == CLS_MGMT && sum.fc[3:2] == 2'd0 && sum.fc[7:4] == SUB_BEACON &&
                     ssid_ok && (!bssid_filter_on || sum.addr3 == bssid_filter);
  assign eapol_ok  = !sum.err && sum.eff >= MIN_CLEAN && phase_reg == PH_EAPOL &&
                     sum.cls == CLS_DATA && sum.fc[3:2] == 2'd2 &&
                     sum.bssid_at == bssid_learned_reg && {1'b0, sum.eff} >= {1'b0, hdr} + 13'd8 &&
                     sum.ether_type == EAPOL_TYPE && slot_free;
  assign slen      = (sum.clean > 12'(FRAME_STORE_BYTES)) ? 12'(FRAME_STORE_BYTES) : sum.clean;

  // Update run state and form the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= PH_HUNT;
      accepted_eapol <= '0;
      slots_used <= '0;
      bssid_learned_reg <= '0;
    end else if (go) begin
      verdict <= V_IGNORE; stored <= 1'b0; slot_index <= '0; stored_length <= '0;
      phase <= phase_reg; eapol_count <= accepted_eapol; learned_bssid <= bssid_learned_reg;
      if (beacon_ok) begin
        verdict <= V_BEACON; stored_length <= slen;
        if (slot_free) begin
          stored <= 1'b1; slot_index <= slots_used[2:0]; slots_used <= slots_used + 4'd1;
        end
        bssid_learned_reg <= sum.addr3; learned_bssid <= sum.addr3;
        phase_reg <= PH_EAPOL; phase <= PH_EAPOL;
      end else if (eapol_ok) begin
        verdict <= V_EAPOL; stored_length <= slen; stored <= 1'b1;
        slot_index <= slots_used[2:0]; slots_used <= slots_used + 4'd1;
        accepted_eapol <= accepted_eapol + 3'd1; eapol_count <= accepted_eapol + 3'd1;
        if (accepted_eapol + 3'd1 >= 3'(EAPOL_LIMIT)) begin
          phase_reg <= PH_DONE; phase <= PH_DONE;
        end
      end
    end
  end
endmodule

@@ rtl/wifi_two_phase_frame_filter_top.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake        | Fields
// input    | push / full      | data_byte last_byte frame_length packet_class rx_error
// result   | pop / empty      | verdict stored slot_index stored_length phase ...
// config   | cfg_we           | cfg_index cfg_data
// One byte per cycle enters the parser while full is low; after the last byte is taken,
// a verdict passes the frame summary and the decision into a 4-entry output queue.
// full is high when that queue cannot take one more in-flight verdict.
// Reset is synchronous; it clears the run state and empties the queue.
`include "wifi_two_phase_frame_filter_top_macros.svh"
module wifi_two_phase_frame_filter_top #(
  parameter int EAPOL_LIMIT       = wtf_pkg::EAPOL_LIMIT_DEF,
  parameter int CAPTURE_SLOTS     = wtf_pkg::CAPTURE_SLOTS_DEF,
  parameter int FRAME_STORE_BYTES = wtf_pkg::FRAME_STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [11:0] frame_length,
  input  logic [1:0]  packet_class,
  input  logic        rx_error,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  verdict,
  output logic        stored,
  output logic [2:0]  slot_index,
  output logic [11:0] stored_length,
  output logic [1:0]  phase,
  output logic [2:0]  eapol_count,
  output logic [47:0] learned_bssid,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import wtf_pkg::*;
  localparam int RW = 2 + 1 + 3 + 12 + 2 + 3 + 48;

  ssid_cfg_t    scfg;
  logic [47:0]  bssid_filter;
  logic         bssid_filter_on;
  logic         in_acc, sum_valid, dec_valid, q_full, q_empty;
  logic [2:0]   q_cnt;
  frame_sum_t   sum;
  logic [255:0] ssid_text;
  logic [1:0]   d_verdict, d_phase;
  logic         d_stored;
  logic [2:0]   d_slot, d_cnt;
  logic [11:0]  d_len;
  logic [47:0]  d_bssid;
  logic [RW-1:0] q_out;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scfg <= '0; bssid_filter <= '0; bssid_filter_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SSID0:   scfg.text[63:0]    <= cfg_data;
        REG_SSID1:   scfg.text[127:64]  <= cfg_data;
        REG_SSID2:   scfg.text[191:128] <= cfg_data;
        REG_SSID3:   scfg.text[255:192] <= cfg_data;
        REG_SSIDLEN: scfg.len           <= cfg_data[5:0];
        REG_BFILT:   bssid_filter       <= cfg_data[47:0];
        REG_BFON:    bssid_filter_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Reserve room for verdicts still in flight
  always_ff @(posedge clk) begin
    if (rst) q_cnt <= '0;
    else q_cnt <= q_cnt + 3'(in_acc && last_byte) - 3'(pop && !q_empty);
  end
  assign full   = (q_cnt >= 3'd4);
  assign in_acc = push && !full;

  wtf_parser u_parser (
    .clk, .rst, .in_valid(in_acc), .data_byte, .last_byte, .frame_length,
    .packet_class, .rx_error, .sum_valid, .sum, .ssid_text
  );

  always_ff @(posedge clk) begin
    if (rst) dec_valid <= 1'b0;
    else dec_valid <= sum_valid;
  end

  wtf_decide #(
    .EAPOL_LIMIT(EAPOL_LIMIT), .CAPTURE_SLOTS(CAPTURE_SLOTS),
    .FRAME_STORE_BYTES(FRAME_STORE_BYTES)
  ) u_decide (
    .clk, .rst, .go(sum_valid), .sum, .ssid_text, .scfg, .bssid_filter, .bssid_filter_on,
    .verdict(d_verdict), .stored(d_stored), .slot_index(d_slot), .stored_length(d_len),
    .phase(d_phase), .eapol_count(d_cnt), .learned_bssid(d_bssid)
  );

  wtf_fifo #(.WIDTH(RW), .DEPTH(4)) u_q (
    .clk, .rst, .wr(dec_valid),
    .wdata({d_verdict, d_stored, d_slot, d_len, d_phase, d_cnt, d_bssid}),
    .rd(pop && !q_empty), .rdata(q_out), .is_empty(q_empty), .is_full(q_full)
  );

  assign empty = q_empty;
  assign {verdict, stored, slot_index, stored_length, phase, eapol_count, learned_bssid} = q_out;

  `WTF_ASSERT_IMPL(a_no_overflow, clk, rst, dec_valid, !q_full)
  `WTF_ASSERT_NEXT(a_sum_to_dec, clk, rst, sum_valid, dec_valid)
  `WTF_ASSERT_IMPL(a_ignored_clean, clk, rst, !q_empty && verdict == V_IGNORE, !stored && stored_length == 12'd0)
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import wtf_pkg::*;

  localparam logic [1:0] CLS_CTRL  = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        stored;
    logic [2:0]  slot_index;
    logic [11:0] stored_length;
    logic [1:0]  phase;
    logic [2:0]  eapol_count;
    logic [47:0] learned_bssid;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [11:0] frame_length = '0;
  logic [1:0]  packet_class = '0;
  logic        rx_error = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  verdict;
  logic        stored;
  logic [2:0]  slot_index;
  logic [11:0] stored_length;
  logic [1:0]  phase;
  logic [2:0]  eapol_count;
  logic [47:0] learned_bssid;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  wifi_two_phase_frame_filter_top DUT (.*);

  always #4 clk = ~clk;

  // Predictor copy of configuration and run state
  logic [63:0] tgt_words [4];
  logic [5:0]  tgt_len;
  logic [47:0] bfilt;
  logic        bfilt_on;
  logic [1:0]  run_phase;
  int          eapol_seen;
  int          slots_taken;
  logic [47:0] bssid_known;
  // per-frame parse state
  int          pos;
  int          clean_seen;
  logic [15:0] fctl;
  logic [47:0] addr3;
  logic        bssid_bad;
  int          ie_start;
  int          ie_tag;
  int          ie_len;
  logic        ssid_hit;
  logic [7:0]  ssid_seen [32];
  logic [15:0] etype;
  logic        err_flag;

  verdict_t    verdict_q [$];
  logic [7:0]  frame_buf [$];
  int          errors = 0;
  bit          steady_tx = 0;
  bit          steady_rx = 0;
  bit          hold_req = 0;

  function automatic void clear_frame_state();
    pos = 0; clean_seen = 0; fctl = '0; addr3 = '0; bssid_bad = 0;
    ie_start = 36; ie_tag = 0; ie_len = 0; ssid_hit = 0; etype = '0; err_flag = 0;
    foreach (ssid_seen[k]) ssid_seen[k] = '0;
  endfunction

  function automatic logic [7:0] tgt_byte(int k);
    return tgt_words[(k >> 3) & 3][8*(k & 7) +: 8];
  endfunction

  function automatic int tgt_eff_len();
    int lim;
    lim = (tgt_len > SSID_MAX) ? SSID_MAX : tgt_len;
    for (int k = 0; k < lim; k++) if (tgt_byte(k) == 0) return k;
    return lim;
  endfunction

  function automatic bit ssid_ok(int eff);
    int t, n, e;
    t = tgt_eff_len();
    if (t == 0) return 1;
    if (!ssid_hit || ie_start + 2 + ie_len > eff) return 0;
    n = (ie_len > SSID_MAX) ? SSID_MAX : ie_len;
    e = n;
    for (int k = 0; k < n; k++) if (ssid_seen[k] == 0) begin e = k; break; end
    if (e != t) return 0;
    for (int k = 0; k < t; k++) if (ssid_seen[k] != tgt_byte(k)) return 0;
    return 1;
  endfunction

  function automatic void parse_byte(int p, logic [7:0] b);
    int ds, start, hdr, n;
    if (p == 0) fctl[7:0] = b;
    if (p == 1) fctl[15:8] = b;
    if (p >= 16 && p < 22) addr3[8*(p-16) +: 8] = b;
    if (p >= 2) begin
      ds = int'(fctl[9:8]);
      start = (ds == 1) ? 4 : ((ds == 2) ? 10 : 16);
      if (p >= start && p < start + 6 && b != bssid_known[8*(p-start) +: 8]) bssid_bad = 1;
      hdr = 24 + (fctl[7] ? 2 : 0) + ((ds == 3) ? 6 : 0);
      if (p == hdr + 6) etype[15:8] = b;
      if (p == hdr + 7) etype[7:0] = b;
    end
    if (!ssid_hit) begin
      if (p == ie_start) begin
        ie_tag = int'(b);
      end else if (p == ie_start + 1) begin
        ie_len = int'(b);
        if (ie_tag == 0) ssid_hit = 1;
        else ie_start += 2 + ie_len;
      end
    end else begin
      n = (ie_len > SSID_MAX) ? SSID_MAX : ie_len;
      if (p >= ie_start + 2 && p < ie_start + 2 + n) ssid_seen[p - ie_start - 2] = b;
    end
  endfunction

  // Advance the predictor by one byte; return 1 with a verdict at the last byte
  function automatic bit predict_byte(logic [7:0] b, logic last, int raw, logic [1:0] cls,
                                      logic err, output verdict_t r);
    int clean, eff, hdr;
    logic [1:0] ftype, ds;
    logic [3:0] sub;
    r = '0;
    clean = (raw > 4) ? raw - 4 : raw;
    if (err) err_flag = 1;
    if (pos < clean) begin
      parse_byte(pos, b);
      clean_seen++;
    end
    if (pos < 4095) pos++;
    if (!last) return 0;
    eff = clean_seen;
    ftype = fctl[3:2];
    sub = fctl[7:4];
    ds = fctl[9:8];
    r.verdict = V_IGNORE;
    if (!err_flag && eff >= MIN_CLEAN) begin
      if (run_phase == PH_HUNT) begin
        if (cls == CLS_MGMT && ftype == 0 && sub == SUB_BEACON && ssid_ok(eff) &&
            (!bfilt_on || addr3 == bfilt)) begin
          r.verdict = V_BEACON;
          if (slots_taken < CAPTURE_SLOTS_DEF) begin
            r.stored = 1;
            r.slot_index = slots_taken[2:0];
            slots_taken++;
          end
          bssid_known = addr3;
          run_phase = PH_EAPOL;
        end
      end else if (run_phase == PH_EAPOL) begin
        hdr = 24 + (sub[3] ? 2 : 0) + ((ds == 3) ? 6 : 0);
        if (cls == CLS_DATA && ftype == 2 && !bssid_bad && eff >= hdr + 8 &&
            etype == EAPOL_TYPE && slots_taken < CAPTURE_SLOTS_DEF) begin
          r.verdict = V_EAPOL;
          r.stored = 1;
          r.slot_index = slots_taken[2:0];
          slots_taken++;
          eapol_seen++;
          if (eapol_seen >= EAPOL_LIMIT_DEF) run_phase = PH_DONE;
        end
      end
    end
    if (r.verdict != V_IGNORE)
      r.stored_length = 12'((clean > FRAME_STORE_BYTES_DEF) ? FRAME_STORE_BYTES_DEF : clean);
    r.phase = run_phase;
    r.eapol_count = eapol_seen[2:0];
    r.learned_bssid = bssid_known;
    clear_frame_state();
    return 1;
  endfunction

  // Send one byte transaction, with random idle cycles ahead of it unless steady_tx is set
  task automatic send_byte(logic [7:0] b, logic last, int raw, logic [1:0] cls, logic err);
    verdict_t r;
    while (!steady_tx && $urandom_range(99) < 7) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    frame_length <= raw[11:0];
    packet_class <= cls;
    rx_error <= err;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_byte(b, last, raw, cls, err, r)) verdict_q.push_back(r);
  endtask

  // raw < 0 means true length plus FCS; earlier bytes carry a random class
  task automatic send_frame(logic [1:0] cls, int raw, int err_at);
    int n;
    n = frame_buf.size();
    if (raw < 0) raw = n + 4;
    for (int i = 0; i < n; i++)
      send_byte(frame_buf[i], i == n - 1, raw,
                (i == n - 1) ? cls : 2'($urandom_range(3)), i == err_at);
  endtask

  task automatic release_input();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_input();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back; call only while idle
  task automatic program_regs(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                              logic [63:0] w3, logic [5:0] len, logic [47:0] filt,
                              logic on);
    logic [63:0] vals [7];
    logic [2:0]  idx [7];
    vals = '{w0, w1, w2, w3, 64'(len), 64'(filt), 64'(on)};
    idx = '{REG_SSID0, REG_SSID1, REG_SSID2, REG_SSID3, REG_SSIDLEN, REG_BFILT, REG_BFON};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tgt_words = '{w0, w1, w2, w3};
    tgt_len = len;
    bfilt = filt;
    bfilt_on = on;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Beacon: 24-byte header, 12 fixed bytes, optional other elements, SSID element, optional trailing element
  task automatic build_beacon(logic [47:0] a3, int pre_elems, int ssid_field,
                              bit use_target);
    int l;
    frame_buf = {};
    frame_buf.push_back(8'h80);
    frame_buf.push_back(8'($urandom));
    for (int i = 2; i < 36; i++) frame_buf.push_back(8'($urandom));
    for (int i = 0; i < 6; i++) frame_buf[16 + i] = a3[8*i +: 8];
    for (int e = 0; e < pre_elems; e++) begin
      l = $urandom_range(6);
      frame_buf.push_back(8'($urandom_range(255, 1)));
      frame_buf.push_back(8'(l));
      for (int i = 0; i < l; i++) frame_buf.push_back(8'($urandom));
    end
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'(ssid_field));
    for (int k = 0; k < ssid_field; k++)
      frame_buf.push_back((use_target && k < 32) ? tgt_byte(k) : 8'($urandom_range(126, 32)));
    if ($urandom_range(1)) begin
      frame_buf.push_back(8'd3);
      frame_buf.push_back(8'd1);
      frame_buf.push_back(8'($urandom));
    end
  endtask

  // Data frame: BSSID at the DS-selected address, LLC/SNAP header, EtherType
  task automatic build_data(bit bad_bssid, bit bad_type);
    logic qos;
    logic [1:0] ds;
    int start, hdr;
    qos = 1'($urandom_range(1));
    ds = 2'($urandom_range(3));
    start = (ds == 1) ? 4 : ((ds == 2) ? 10 : 16);
    hdr = 24 + (qos ? 2 : 0) + ((ds == 3) ? 6 : 0);
    frame_buf = {};
    frame_buf.push_back(qos ? 8'h88 : 8'h08);
    frame_buf.push_back({6'($urandom), ds});
    for (int i = 2; i < hdr; i++) frame_buf.push_back(8'($urandom));
    for (int i = 0; i < 6; i++) frame_buf[start + i] = bssid_known[8*i +: 8];
    if (bad_bssid) frame_buf[start + $urandom_range(5)] ^= 8'($urandom_range(255, 1));
    frame_buf.push_back(8'hAA); frame_buf.push_back(8'hAA); frame_buf.push_back(8'h03);
    frame_buf.push_back(8'h00); frame_buf.push_back(8'h00); frame_buf.push_back(8'h00);
    frame_buf.push_back(EAPOL_TYPE[15:8]);
    frame_buf.push_back(bad_type ? 8'($urandom) : EAPOL_TYPE[7:0]);
    repeat ($urandom_range(10)) frame_buf.push_back(8'($urandom));
  endtask

  task automatic build_noise(int n, logic [7:0] fill, bit random_fill);
    frame_buf = {};
    repeat (n) frame_buf.push_back(random_fill ? 8'($urandom) : fill);
  endtask

  function automatic logic [47:0] not_filter();
    logic [47:0] a;
    a = 48'({$urandom, $urandom});
    if (a == bfilt) a[0] = ~a[0];
    return a;
  endfunction

  // Hunt phase: every rejection reason while nothing can be accepted
  task automatic test_hunt_rejects();
    wait_drained();
    program_regs(64'h0000_0000_3161_6c73, '0, '0, '0, 6'd4, 48'h665544332211, 1'b1);
    build_beacon(48'h665544332211, 0, 4, 1);
    frame_buf = frame_buf[0:19];
    send_frame(CLS_MGMT, -1, -1);                    // short frame
    build_beacon(48'h665544332211, 1, 4, 1);
    send_frame(CLS_MGMT, -1, 5);                     // rx error mid-frame
    build_beacon(48'h665544332211, 0, 4, 1);
    send_frame(CLS_CTRL, -1, -1);                    // wrong class on last byte
    build_beacon(48'h665544332211, 0, 4, 1);
    frame_buf[0] = 8'h50;
    send_frame(CLS_MGMT, -1, -1);                    // probe response, not beacon
    build_beacon(48'h665544332211, 2, 5, 0);
    send_frame(CLS_MGMT, -1, -1);                    // SSID mismatch
    build_beacon(48'h665544332211, 0, 4, 1);
    send_frame(CLS_MGMT, 42, -1);                    // element overruns clean length
    build_beacon(48'h665544332212, 0, 4, 1);
    send_frame(CLS_MGMT, -1, -1);                    // address 3 off the filter
    build_beacon(48'h665544332211, 0, 4, 1);
    send_frame(CLS_OTHER, -1, -1);
    build_noise(30, 8'h00, 0);
    send_frame(CLS_MGMT, 0, -1);
    build_noise(30, 8'hFF, 0);
    send_frame(CLS_DATA, 4095, -1);
    build_noise(3, 8'h00, 1);
    send_frame(CLS_MGMT, 4, -1);
    build_noise(1, 8'h00, 1);
    send_frame(CLS_MGMT, 1, -1);
  endtask

  // Hunt phase with random beacons under settings that cannot accept
  task automatic test_hunt_random();
    int sel;
    for (int cfg = 0; cfg < 2; cfg++) begin
      wait_drained();
      if (cfg == 0)
        program_regs('1, '1, '1, '1, 6'd63, '1, 1'b1);
      else
        program_regs(64'h0000_0000_0041_4243 | (rand64() << 32), rand64(), '0, '0,
                     6'($urandom_range(40)), '0, 1'b1);
      steady_tx = 0;
      for (int f = 0; f < 5; f++) begin
        if (f == 1) steady_tx = 1;
        if (f == 4) steady_tx = 0;
        sel = $urandom_range(9);
        if (sel < 7) begin
          build_beacon(not_filter(), $urandom_range(3), $urandom_range(40), $urandom_range(1));
          send_frame(($urandom_range(7) == 0) ? CLS_CTRL : CLS_MGMT,
                     ($urandom_range(5) == 0) ? $urandom_range(80) : -1,
                     ($urandom_range(9) == 0) ? 10 : -1);
        end else begin
          build_noise($urandom_range(60, 1), 8'h00, 1);
          send_frame(2'($urandom_range(3)), $urandom_range(4095), -1);
        end
      end
    end
  endtask

  // Accept a matching beacon after a truncated-SSID near miss
  task automatic test_accept_beacon();
    logic [47:0] ap;
    ap = 48'({$urandom, $urandom});
    wait_drained();
    program_regs(64'h0000_0000_3161_7473, '0, '0, '0, 6'd4, ap, 1'b1);
    build_beacon(ap, 1, 3, 1);
    send_frame(CLS_MGMT, -1, -1);                    // truncated SSID
    build_beacon(ap, 0, 6, 1);
    send_frame(CLS_MGMT, -1, -1);                    // zero byte ends element text
    build_beacon(ap, 3, 4, 1);
    send_frame(CLS_MGMT, -1, -1);
    if (run_phase == PH_HUNT) begin
      wait_drained();
      program_regs(rand64(), rand64(), rand64(), rand64(), 6'd0, '0, 1'b0);
      build_beacon(48'({$urandom, $urandom}), 0, 2, 0);
      send_frame(CLS_MGMT, -1, -1);
    end
  endtask

  // Capture phase: mostly data frames, some of them near misses, with a long receiver hold-off
  task automatic test_eapol_random();
    int sel;
    steady_tx = 0;
    for (int f = 0; f < 10; f++) begin
      if (f == 2) hold_req = 1;
      sel = $urandom_range(9);
      if (sel < 6) begin
        build_data($urandom_range(3) == 0, $urandom_range(2) == 0);
        send_frame(($urandom_range(7) == 0) ? CLS_MGMT : CLS_DATA,
                   ($urandom_range(7) == 0) ? $urandom_range(50) : -1,
                   ($urandom_range(11) == 0) ? 3 : -1);
      end else if (sel < 8) begin
        build_beacon(bssid_known, 0, 4, 1);
        send_frame(CLS_MGMT, -1, -1);
      end else begin
        build_noise($urandom_range(40, 1), 8'h00, 1);
        send_frame(2'($urandom_range(3)), -1, -1);
      end
    end
  endtask

  // Complete phase: good data frames, which are ignored once the capture phase is done
  task automatic test_done_phase();
    for (int f = 0; f < 4; f++) begin
      build_data(0, 0);
      send_frame(CLS_DATA, -1, -1);
    end
    if (run_phase != PH_DONE) begin
      for (int f = 0; f < 2; f++) begin
        build_data(0, 0);
        send_frame(CLS_DATA, -1, -1);
      end
    end
  endtask

  // Receiver: check each result transaction, pace pop with stalls and a hold-off
  initial begin
    verdict_t exp, act;
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        act = '{verdict, stored, slot_index, stored_length, phase, eapol_count,
                learned_bssid};
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, act);
          errors++;
        end else begin
          exp = verdict_q.pop_front();
          if (act !== exp) begin
            $display("%0t mismatch: expected v=%0d st=%0d sl=%0d len=%0d ph=%0d n=%0d b=%h",
                     $time, exp.verdict, exp.stored, exp.slot_index, exp.stored_length,
                     exp.phase, exp.eapol_count, exp.learned_bssid);
            $display("%0t           actual   v=%0d st=%0d sl=%0d len=%0d ph=%0d n=%0d b=%h",
                     $time, act.verdict, act.stored, act.slot_index, act.stored_length,
                     act.phase, act.eapol_count, act.learned_bssid);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        pop <= steady_rx || ($urandom_range(99) >= 7);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || rst) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    tgt_words = '{default: '0};
    tgt_len = '0; bfilt = '0; bfilt_on = 0;
    run_phase = PH_HUNT; eapol_seen = 0; slots_taken = 0; bssid_known = '0;
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hunt_rejects();
    test_hunt_random();
    test_accept_beacon();
    steady_rx = 1;
    test_eapol_random();
    steady_rx = 0;
    test_done_phase();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
